[src/ilir_pkg.sv]
// Package for the indexed list: sizes, codes, state and control types, helpers.
package ilir_pkg;

  localparam int DEPTH   = 64;
  localparam int ELEM_W  = 32;
  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int GRP_N   = 8;
  localparam int GRP_CNT = (DEPTH + GRP_N - 1) / GRP_N;

  // Command codes; the fourth code has no meaning and is refused.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_GATHER,
    S_RESULT
  } state_t;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [CMP_W-1:0]  pos;
    logic [ELEM_W-1:0] val;
  } cell_ctl_t;

  // Result of one beat as held by the controller.
  typedef struct packed {
    logic             valid;
    logic             rd_ok;
    logic [1:0]       status;
    logic [CNT_W-1:0] count;
  } res_t;

  // Fit a port word into the stored element width.
  function automatic logic [ELEM_W-1:0] to_elem(input logic [DATA_W-1:0] v);
    logic [ELEM_W+DATA_W-1:0] w;
    w = {{ELEM_W{1'b0}}, v};
    return w[ELEM_W-1:0];
  endfunction

  // Fit a stored element onto the read port.
  function automatic logic [DATA_W-1:0] to_data(input logic [ELEM_W-1:0] e);
    logic [ELEM_W+DATA_W-1:0] w;
    w = {{DATA_W{1'b0}}, e};
    return w[DATA_W-1:0];
  endfunction

endpackage

[src/indexed_list_insert_remove.sv]
// Top level of the indexed list: controller, row of cells and read gather tree.
// An accepted beat goes through S_EXEC, S_GATHER, S_RESULT; out_valid strobes in S_RESULT.
// A new beat is not taken while one is in flight; start is taken again in the result cycle.
// The steps are cell update, per-group OR of the read words, then final OR and output.
// Reset clears the controller state and the element count; cell contents stay unknown.
// The receiver cannot stall: each result is shown for exactly one cycle.
module indexed_list_insert_remove (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_cmd,
  input  logic [ilir_pkg::POS_W-1:0]  in_position,
  input  logic [ilir_pkg::DATA_W-1:0] in_value,
  output logic                        out_valid,
  output logic [1:0]                  out_status,
  output logic [ilir_pkg::DATA_W-1:0] out_read_value,
  output logic [ilir_pkg::CNT_W-1:0]  out_count
);
  import ilir_pkg::*;

  cell_ctl_t         ctl;
  res_t              res;
  logic              gather;
  logic [ELEM_W-1:0] entry [DEPTH];
  logic [ELEM_W-1:0] rd    [DEPTH];
  logic [ELEM_W-1:0] grp_r [GRP_CNT];
  logic [ELEM_W-1:0] grp_nxt [GRP_CNT];
  logic [ELEM_W-1:0] rd_all;

  ilir_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (in_cmd),
    .pos    (in_position),
    .val    (in_value),
    .busy   (busy),
    .ctl    (ctl),
    .gather (gather),
    .res    (res)
  );

  // Row of cells, each wired to its neighbors; an end cell sees its own entry on the open side.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = entry[i];
    end else begin : g_mid_l
      assign left_w = entry[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = entry[i];
    end else begin : g_mid_r
      assign right_w = entry[i+1];
    end
    ilir_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .idx     (CMP_W'(i)),
      .left_i  (left_w),
      .right_i (right_w),
      .entry_o (entry[i]),
      .rd_o    (rd[i])
    );
  end

  // First tree level: OR the gated read words within each group.
  always_comb begin
    for (int g = 0; g < GRP_CNT; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP_N; k++) begin
        if (g * GRP_N + k < DEPTH) begin
          grp_nxt[g] = grp_nxt[g] | rd[g * GRP_N + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (gather) begin
      for (int g = 0; g < GRP_CNT; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  // Final level: OR the group words.
  always_comb begin
    rd_all = '0;
    for (int g = 0; g < GRP_CNT; g++) begin
      rd_all = rd_all | grp_r[g];
    end
  end

  assign out_valid      = res.valid;
  assign out_status     = res.status;
  assign out_count      = res.count;
  assign out_read_value = res.rd_ok ? to_data(rd_all) : '0;

endmodule

[src/ilir_cell.sv]
// One list cell: holds one element and takes from its neighbors on a shift.
module ilir_cell (
  input  logic                       clk,
  input  ilir_pkg::cell_ctl_t        ctl,
  input  logic [ilir_pkg::CMP_W-1:0] idx,
  input  logic [ilir_pkg::ELEM_W-1:0] left_i,
  input  logic [ilir_pkg::ELEM_W-1:0] right_i,
  output logic [ilir_pkg::ELEM_W-1:0] entry_o,
  output logic [ilir_pkg::ELEM_W-1:0] rd_o
);
  import ilir_pkg::*;

  logic [ELEM_W-1:0] entry_r, entry_nxt;
  logic [ELEM_W-1:0] rd_r, rd_nxt;

  // Insert moves cells above the position up; remove pulls cells at and above it down.
  always_comb begin
    entry_nxt = entry_r;
    priority if (ctl.ins && (idx > ctl.pos)) begin
      entry_nxt = left_i;
    end else if (ctl.ins && (idx == ctl.pos)) begin
      entry_nxt = ctl.val;
    end else if (ctl.rem && (idx >= ctl.pos)) begin
      entry_nxt = right_i;
    end else begin
      entry_nxt = entry_r;
    end
    rd_nxt = (idx == ctl.pos) ? entry_r : '0;
  end

  // Element and gated read word; payload only, no reset.
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    rd_r    <= rd_nxt;
  end

  assign entry_o = entry_r;
  assign rd_o    = rd_r;

endmodule

[src/ilir_ctrl.sv]
// Controller: command sequencing, element count and status.
module ilir_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [1:0]                 cmd,
  input  logic [ilir_pkg::POS_W-1:0] pos,
  input  logic [ilir_pkg::DATA_W-1:0] val,
  output logic                       busy,
  output ilir_pkg::cell_ctl_t        ctl,
  output logic                       gather,
  output ilir_pkg::res_t             res
);
  import ilir_pkg::*;

  state_t            state_r, state_nxt;
  logic [1:0]        cmd_r;
  logic [CMP_W-1:0]  pos_r;
  logic [ELEM_W-1:0] val_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [CMP_W-1:0]  cnt_ext;
  logic              accept;

  assign cnt_ext = CMP_W'(count_r);
  assign busy    = (state_r != S_IDLE) && (state_r != S_RESULT);
  assign accept  = start && !busy;

  // Next state, command decode and cell control.
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    rd_ok_nxt  = rd_ok_r;
    ctl.ins    = 1'b0;
    ctl.rem    = 1'b0;
    ctl.pos    = pos_r;
    ctl.val    = val_r;
    gather     = 1'b0;
    unique case (state_r)
      S_IDLE, S_RESULT: begin
        state_nxt = accept ? S_EXEC : S_IDLE;
      end
      S_EXEC: begin
        state_nxt  = S_GATHER;
        status_nxt = ST_RANGE;
        rd_ok_nxt  = 1'b0;
        unique case (cmd_r)
          CMD_INSERT: begin
            if (pos_r > cnt_ext) begin
              status_nxt = ST_RANGE;
            end else if (cnt_ext >= CMP_W'(DEPTH)) begin
              status_nxt = ST_FULL;
            end else begin
              status_nxt = ST_DONE;
              ctl.ins    = 1'b1;
              count_nxt  = count_r + 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (pos_r < cnt_ext) begin
              status_nxt = ST_DONE;
              ctl.rem    = 1'b1;
              count_nxt  = count_r - 1'b1;
            end
          end
          CMD_READ: begin
            if (pos_r < cnt_ext) begin
              status_nxt = ST_DONE;
              rd_ok_nxt  = 1'b1;
            end
          end
          default: begin
            status_nxt = ST_RANGE;
          end
        endcase
      end
      S_GATHER: begin
        gather    = 1'b1;
        state_nxt = S_RESULT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Captured command and per-beat result fields.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= cmd;
      pos_r <= CMP_W'(pos);
      val_r <= to_elem(val);
    end
    status_r <= status_nxt;
    rd_ok_r  <= rd_ok_nxt;
  end

  assign res.valid  = (state_r == S_RESULT);
  assign res.rd_ok  = rd_ok_r;
  assign res.status = status_r;
  assign res.count  = count_r;

  // The count never passes the list capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above capacity");

  // A successful insert grows the count by one.
  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.ins |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the count");

  // Insert and remove never shift the row together.
  a_ins_rem: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.ins && ctl.rem))
    else $error("insert and remove at once");

  // Between two result strobes out_valid stays low through the execute and gather states.
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> !res.valid ##1 !res.valid)
    else $error("result strobes too close");

endmodule

[verif/indexed_list_insert_remove_tb.sv]
// Self-checking testbench for the indexed list: table-driven directed beats, then random phases.
module indexed_list_insert_remove_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ilir_pkg::*;

  // The fourth command code has no operation behind it.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_BEATS   = 1425;
  localparam int WATCHDOG_LIMIT = 500;
  localparam int DRAIN_CYCLES   = 8;

  // One result beat as the block should present it.
  typedef struct packed {
    logic [1:0]        status;
    logic [DATA_W-1:0] rd;
    logic [CNT_W-1:0]  count;
  } list_result_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct packed {
    logic [1:0]        cmd;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              typed;
    list_result_t      want;
  } dir_row_t;

  localparam int DIR_ROWS_N = 25;
  localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
    // Empty list: every position is past the end.
    '{CMD_READ,   7'd0,   32'h0000_0000, 1'b1, '{ST_RANGE, 32'd0, 7'd0}},
    '{CMD_REMOVE, 7'd0,   32'h0000_0000, 1'b1, '{ST_RANGE, 32'd0, 7'd0}},
    '{CMD_INSERT, 7'd1,   32'h0000_0005, 1'b1, '{ST_RANGE, 32'd0, 7'd0}},
    '{CMD_INSERT, 7'd127, 32'hFFFF_FFFF, 1'b1, '{ST_RANGE, 32'd0, 7'd0}},
    // First elements, with the data extremes.
    '{CMD_INSERT, 7'd0,   32'hFFFF_FFFF, 1'b1, '{ST_DONE, 32'd0, 7'd1}},
    '{CMD_READ,   7'd0,   32'h0000_0000, 1'b1, '{ST_DONE, 32'hFFFF_FFFF, 7'd1}},
    '{CMD_INSERT, 7'd0,   32'h0000_0000, 1'b1, '{ST_DONE, 32'd0, 7'd2}},
    '{CMD_INSERT, 7'd2,   32'hA5A5_5A5A, 1'b1, '{ST_DONE, 32'd0, 7'd3}},
    '{CMD_INSERT, 7'd1,   32'h1234_5678, 1'b0, '0},
    '{CMD_READ,   7'd0,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,   7'd1,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,   7'd2,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,   7'd3,   32'hDEAD_BEEF, 1'b0, '0},
    // Unused command and positions at and beyond the end.
    '{CMD_UNUSED, 7'd0,   32'h5555_AAAA, 1'b1, '{ST_RANGE, 32'd0, 7'd4}},
    '{CMD_READ,   7'd4,   32'h0000_0000, 1'b1, '{ST_RANGE, 32'd0, 7'd4}},
    '{CMD_READ,   7'd64,  32'h0000_0000, 1'b1, '{ST_RANGE, 32'd0, 7'd4}},
    '{CMD_REMOVE, 7'd4,   32'h0000_0000, 1'b1, '{ST_RANGE, 32'd0, 7'd4}},
    // Removes from the middle, from the end and from the front.
    '{CMD_REMOVE, 7'd1,   32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE, 7'd2,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,   7'd0,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,   7'd1,   32'h0000_0000, 1'b0, '0},
    '{CMD_REMOVE, 7'd0,   32'h0000_0000, 1'b0, '0},
    '{CMD_READ,   7'd0,   32'h0000_0000, 1'b0, '0},
    '{CMD_INSERT, 7'd0,   32'h8000_0001, 1'b0, '0},
    '{CMD_READ,   7'd127, 32'h0000_0000, 1'b1, '{ST_RANGE, 32'd0, 7'd2}}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          in_cmd = 2'd0;
  logic [POS_W-1:0]    in_position = '0;
  logic [DATA_W-1:0]   in_value = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [DATA_W-1:0]   out_read_value;
  logic [CNT_W-1:0]    out_count;

  // Shadow copy of the list and the results still owed by the block.
  logic [ELEM_W-1:0]   shadow_list [DEPTH];
  int                  shadow_count = 0;
  list_result_t        pending_results [$];
  int                  error_count = 0;
  int                  quiet_cycles = 0;

  indexed_list_insert_remove i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_position    (in_position),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one command to the shadow list and return the result it gives.
  function automatic list_result_t list_apply(input logic [1:0] cmd,
                                              input logic [POS_W-1:0] pos,
                                              input logic [DATA_W-1:0] val);
    list_result_t r;
    int p;
    r.status = ST_RANGE;
    r.rd = '0;
    p = int'(pos);
    case (cmd)
      CMD_INSERT: begin
        // The range test wins over the full test.
        if (p > shadow_count) begin
          r.status = ST_RANGE;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > p; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[p] = val[ELEM_W-1:0];
          shadow_count++;
          r.status = ST_DONE;
        end
      end
      CMD_REMOVE: begin
        if (p < shadow_count) begin
          for (int i = p; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
          r.status = ST_DONE;
        end
      end
      CMD_READ: begin
        if (p < shadow_count) begin
          r.rd = DATA_W'(shadow_list[p]);
          r.status = ST_DONE;
        end
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = CNT_W'(shadow_count);
    return r;
  endfunction

  // Mostly legal positions, some just past the end, some far out.
  function automatic logic [POS_W-1:0] pick_position(input logic [1:0] cmd);
    int top;
    int roll;
    top = (cmd == CMD_INSERT) ? shadow_count : shadow_count - 1;
    roll = $urandom_range(0, 99);
    if (roll < 85 && top >= 0) return POS_W'($urandom_range(0, top));
    if (roll < 92) return POS_W'(top + 1);
    if (roll < 96) return POS_W'($urandom_range(DEPTH, 127));
    return POS_W'($urandom);
  endfunction

  // Sender gaps: mostly none or short, now and then long.
  function automatic int pick_gap(input bit quiet);
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Present one beat and hold it until the block takes it.
  task automatic send_beat(input logic [1:0] cmd, input logic [POS_W-1:0] pos,
                           input logic [DATA_W-1:0] val, input logic typed,
                           input list_result_t typed_want);
    list_result_t predicted;
    @(negedge clk);
    start       <= 1'b1;
    in_cmd      <= cmd;
    in_position <= pos;
    in_value    <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = list_apply(cmd, pos, val);
    pending_results.push_back(typed ? typed_want : predicted);
  endtask

  // Leave start low for a number of cycles with noise on the data ports.
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      start       <= 1'b0;
      in_cmd      <= 2'($urandom);
      in_position <= POS_W'($urandom);
      in_value    <= $urandom;
    end
  endtask

  // Result checker and watchdog.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status || out_read_value !== want.rd ||
              out_count !== want.count) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch at %0t: status %0d/%0d read_value %h/%h count %0d/%0d",
                       $realtime, want.status, out_status, want.rd, out_read_value,
                       want.count, out_count);
          end
        end
      end
      if ((start && !busy) || out_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    int sent;
    int phase_idx;
    int phase_len;
    int roll;
    bit quiet;
    logic [1:0] cmd;
    sent = 0;
    phase_idx = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIR_ROWS[k]) begin
      send_beat(DIR_ROWS[k].cmd, DIR_ROWS[k].pos, DIR_ROWS[k].val, DIR_ROWS[k].typed,
                DIR_ROWS[k].want);
      idle_cycles(pick_gap(1'b0));
    end

    // Phases rotate through growing, mixed and shrinking traffic so the list fills up
    // and empties out repeatedly.
    while (sent < RANDOM_BEATS) begin
      phase_len = $urandom_range(80, 160);
      quiet = ($urandom_range(0, 3) == 0);
      for (int j = 0; j < phase_len && sent < RANDOM_BEATS; j++) begin
        roll = $urandom_range(0, 99);
        case (phase_idx % 3)
          0: cmd = (roll < 85) ? CMD_INSERT : (roll < 90) ? CMD_REMOVE :
                   (roll < 96) ? CMD_READ : CMD_UNUSED;
          1: cmd = (roll < 35) ? CMD_INSERT : (roll < 65) ? CMD_REMOVE :
                   (roll < 96) ? CMD_READ : CMD_UNUSED;
          default: cmd = (roll < 10) ? CMD_INSERT : (roll < 80) ? CMD_REMOVE :
                         (roll < 96) ? CMD_READ : CMD_UNUSED;
        endcase
        send_beat(cmd, pick_position(cmd), $urandom, 1'b0, '0);
        sent++;
        idle_cycles(pick_gap(quiet));
      end
      // Hold off between phases until every owed result has come back.
      idle_cycles(1);
      while (pending_results.size() != 0) @(posedge clk);
      phase_idx++;
    end

    idle_cycles(1);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
